// ===== rtl/rgb_to_rgbw_channel_mapper_defines.svh =====
// Assertion macros shared by the RGB to RGBW channel mapper.
`ifndef RGB_TO_RGBW_CHANNEL_MAPPER_DEFINES_SVH
`define RGB_TO_RGBW_CHANNEL_MAPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RGBW_ASSERT_IMPLY(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) \
		(ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RGBW_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!(rst_n_sig)) \
		(ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rgbw_pkg.sv =====
// Types, constants and helper functions of the RGB to RGBW channel mapper.
`timescale 1ns / 1ps
`default_nettype none

package rgbw_pkg;

	// Widths.
	localparam int unsigned NUM_STAGES = 6;
	localparam int unsigned LVL_W      = 8;
	localparam int unsigned MSG_W      = 3;
	localparam int unsigned STRIP_W    = 4;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned PCT_W      = 7;
	localparam int unsigned DIVIDEND_W = 15;
	localparam int unsigned PROD_W     = 15;
	localparam int unsigned RECIP_W    = 14;
	localparam int unsigned MUL_W      = PROD_W + RECIP_W;
	localparam int unsigned RECIP_SHIFT = 20;

	// Arithmetic constants. RECIP_100 / 2**20 divides by 100 exactly for inputs below 43690.
	localparam logic [PCT_W-1:0]   PCT_FULL  = PCT_W'(100);
	localparam logic [LVL_W-1:0]   LVL_MAX   = LVL_W'(255);
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(10486);

	// Register reset values.
	localparam logic [STRIP_W-1:0] STRIP_RESET     = STRIP_W'(3);
	localparam logic [LVL_W-1:0]   REF_RED_RESET   = LVL_W'(255);
	localparam logic [LVL_W-1:0]   REF_GREEN_RESET = LVL_W'(170);
	localparam logic [LVL_W-1:0]   REF_BLUE_RESET  = LVL_W'(70);

	// Strip kinds.
	localparam logic [STRIP_W-1:0] STRIP_SINGLE   = STRIP_W'(1);
	localparam logic [STRIP_W-1:0] STRIP_CCT      = STRIP_W'(2);
	localparam logic [STRIP_W-1:0] STRIP_RGB      = STRIP_W'(3);
	localparam logic [STRIP_W-1:0] STRIP_RGBW     = STRIP_W'(4);
	localparam logic [STRIP_W-1:0] STRIP_RGBWWW   = STRIP_W'(5);
	localparam logic [STRIP_W-1:0] STRIP_RGBW_ALT = STRIP_W'(14);

	// Message kinds.
	localparam logic [MSG_W-1:0] MSG_SINGLE = MSG_W'(1);
	localparam logic [MSG_W-1:0] MSG_RGB    = MSG_W'(3);
	localparam logic [MSG_W-1:0] MSG_RGBW   = MSG_W'(4);
	localparam logic [MSG_W-1:0] MSG_RGBWWW = MSG_W'(5);

	// Status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK       = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] STATUS_BAD_CONV = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] STATUS_NO_MAP   = STATUS_W'(2);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STRIP_TYPE      = 2'd0,
		REG_WHITE_REF_RED   = 2'd1,
		REG_WHITE_REF_GREEN = 2'd2,
		REG_WHITE_REF_BLUE  = 2'd3
	} cfg_reg_t;

	// How a message is converted for the current strip.
	typedef enum logic [1:0] {
		MODE_INVALID    = 2'd0,
		MODE_PASS       = 2'd1,
		MODE_EXTRACT    = 2'd2,
		MODE_DROP_WHITE = 2'd3
	} mode_t;

	typedef struct packed {
		logic [MSG_W-1:0] message_type;
		logic [LVL_W-1:0] red;
		logic [LVL_W-1:0] green;
		logic [LVL_W-1:0] blue;
		logic [LVL_W-1:0] white;
		logic [LVL_W-1:0] warm_white;
	} in_word_t;

	typedef struct packed {
		logic [LVL_W-1:0]    chan_a;
		logic [LVL_W-1:0]    chan_b;
		logic [LVL_W-1:0]    chan_c;
		logic [LVL_W-1:0]    chan_d;
		logic [LVL_W-1:0]    chan_e;
		logic [STATUS_W-1:0] status;
	} out_word_t;

	// Data that rides along the pipeline: lane 0 red, lane 1 green, lane 2 blue.
	typedef struct packed {
		mode_t                  mode;
		logic [STRIP_W-1:0]     strip;
		logic [2:0][LVL_W-1:0]  rgb;
		logic [LVL_W-1:0]       white;
		logic [LVL_W-1:0]       warm_white;
		logic [2:0][LVL_W-1:0]  wref;
	} side_t;

	// Partial state of one restoring division.
	typedef struct packed {
		logic [DIVIDEND_W-1:0] rem;
		logic [PCT_W-1:0]      quo;
	} div_t;

	// Pipeline control: per-stage load enables and valid bits.
	typedef struct packed {
		logic [NUM_STAGES-1:0] adv;
		logic [NUM_STAGES-1:0] vld;
	} pipe_ctl_t;

	// Decide the conversion from message kind and strip kind.
	function automatic mode_t decode_mode(logic [MSG_W-1:0] mt, logic [STRIP_W-1:0] st);
		mode_t m;
		logic  same;
		same = (mt >= MSG_SINGLE) && (mt <= MSG_RGBWWW) && (STRIP_W'(mt) == st);
		if (mt == MSG_RGB && (st == STRIP_RGBW || st == STRIP_RGBW_ALT)) begin
			m = MODE_EXTRACT;
		end else if (mt == MSG_RGB && st == STRIP_RGBWWW) begin
			m = MODE_DROP_WHITE;
		end else if (same) begin
			m = MODE_PASS;
		end else if (mt == MSG_RGBW && st == STRIP_RGBW_ALT) begin
			m = MODE_PASS;
		end else begin
			m = MODE_INVALID;
		end
		return m;
	endfunction

	// One restoring step: try to take den * 2**k off the remainder.
	function automatic div_t div_step(div_t x, logic [LVL_W-1:0] den, int unsigned k);
		div_t                  y;
		logic [DIVIDEND_W-1:0] trial;
		y = x;
		trial = DIVIDEND_W'(den) << k;
		if (x.rem >= trial) begin
			y.rem = x.rem - trial;
			y.quo = x.quo | (PCT_W'(1) << k);
		end
		return y;
	endfunction

	// Floor division by 100 through a reciprocal multiply.
	function automatic logic [LVL_W-1:0] div100(logic [PROD_W-1:0] x);
		logic [MUL_W-1:0] m;
		m = MUL_W'(x) * MUL_W'(RECIP_100);
		return m[RECIP_SHIFT +: LVL_W];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rgbw_pipe_ctrl.sv =====
// Valid bits and load enables of the six-stage mapper pipeline.
`timescale 1ns / 1ps
`default_nettype none

module rgbw_pipe_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              out_stall,
	output rgbw_pkg::pipe_ctl_t    ctl,
	output logic                   in_stall
);
	import rgbw_pkg::*;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES:0]   rdy;

	// A stage may load when it is empty or its contents move on.
	always_comb begin
		rdy[NUM_STAGES] = !out_stall;
		for (int i = NUM_STAGES - 1; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
	end

	// Valid bits move with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign ctl.adv  = rdy[NUM_STAGES-1:0];
	assign ctl.vld  = vld_q;
	assign in_stall = !rdy[0];

endmodule

`default_nettype wire

// ===== rtl/rgbw_div.sv =====
// Three-stage divider that finds the white percentage of a colour word.
`timescale 1ns / 1ps
`default_nettype none

module rgbw_div (
	input  wire logic                          clk,
	input  wire rgbw_pkg::pipe_ctl_t           ctl,
	input  wire rgbw_pkg::side_t               side_in,
	output rgbw_pkg::side_t                    side_s3,
	output logic [rgbw_pkg::PCT_W-1:0]         pct_s3
);
	import rgbw_pkg::*;

	div_t  [2:0] div_d1;
	div_t  [2:0] div_d2;
	div_t  [2:0] div_d3;
	div_t  [2:0] div_s1;
	div_t  [2:0] div_s2;
	logic  [2:0] act_d1;
	logic  [2:0] act_s1;
	logic  [2:0] act_s2;
	side_t       side_s1;
	side_t       side_s2;
	logic [PCT_W-1:0] pct_d3;

	// Stage 1: form level * 100 and take the two top quotient bits.
	// A lane limits the percentage only when its level is below the reference.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			div_d1[i].rem = DIVIDEND_W'(side_in.rgb[i]) * DIVIDEND_W'(PCT_FULL);
			div_d1[i].quo = '0;
			div_d1[i] = div_step(div_d1[i], side_in.wref[i], 6);
			div_d1[i] = div_step(div_d1[i], side_in.wref[i], 5);
			act_d1[i] = side_in.rgb[i] < side_in.wref[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[0]) begin
			div_s1  <= div_d1;
			act_s1  <= act_d1;
			side_s1 <= side_in;
		end
	end

	// Stage 2: the middle three quotient bits.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			div_d2[i] = div_s1[i];
			div_d2[i] = div_step(div_d2[i], side_s1.wref[i], 4);
			div_d2[i] = div_step(div_d2[i], side_s1.wref[i], 3);
			div_d2[i] = div_step(div_d2[i], side_s1.wref[i], 2);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[1]) begin
			div_s2  <= div_d2;
			act_s2  <= act_s1;
			side_s2 <= side_s1;
		end
	end

	// Stage 3: last two quotient bits, then the least percentage of the lanes.
	always_comb begin
		pct_d3 = PCT_FULL;
		for (int i = 0; i < 3; i++) begin
			div_d3[i] = div_s2[i];
			div_d3[i] = div_step(div_d3[i], side_s2.wref[i], 1);
			div_d3[i] = div_step(div_d3[i], side_s2.wref[i], 0);
			if (act_s2[i] && div_d3[i].quo < pct_d3) begin
				pct_d3 = div_d3[i].quo;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[2]) begin
			pct_s3  <= pct_d3;
			side_s3 <= side_s2;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rgbw_scale.sv =====
// Two stages that scale the white reference and the white level by the percentage.
`timescale 1ns / 1ps
`default_nettype none

module rgbw_scale (
	input  wire logic                              clk,
	input  wire rgbw_pkg::pipe_ctl_t               ctl,
	input  wire rgbw_pkg::side_t                   side_s3,
	input  wire logic [rgbw_pkg::PCT_W-1:0]        pct_s3,
	output rgbw_pkg::side_t                        side_s5,
	output logic [2:0][rgbw_pkg::LVL_W-1:0]        scaled_s5,
	output logic [rgbw_pkg::LVL_W-1:0]             white_s5
);
	import rgbw_pkg::*;

	logic [2:0][PROD_W-1:0] prod_s4;
	logic [PROD_W-1:0]      prod_w_s4;
	side_t                  side_s4;

	// Stage 4: reference * percentage per lane, and 255 * percentage for white.
	always_ff @(posedge clk) begin
		if (ctl.adv[3]) begin
			for (int i = 0; i < 3; i++) begin
				prod_s4[i] <= PROD_W'(side_s3.wref[i]) * PROD_W'(pct_s3);
			end
			prod_w_s4 <= PROD_W'(pct_s3) * PROD_W'(LVL_MAX);
			side_s4   <= side_s3;
		end
	end

	// Stage 5: divide every product by 100.
	always_ff @(posedge clk) begin
		if (ctl.adv[4]) begin
			for (int i = 0; i < 3; i++) begin
				scaled_s5[i] <= div100(prod_s4[i]);
			end
			white_s5 <= div100(prod_w_s4);
			side_s5  <= side_s4;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rgbw_map.sv =====
// Final stage: applies the conversion and maps the colour onto five channels.
`timescale 1ns / 1ps
`default_nettype none

module rgbw_map (
	input  wire logic                              clk,
	input  wire rgbw_pkg::pipe_ctl_t               ctl,
	input  wire rgbw_pkg::side_t                   side_s5,
	input  wire logic [2:0][rgbw_pkg::LVL_W-1:0]   scaled_s5,
	input  wire logic [rgbw_pkg::LVL_W-1:0]        white_s5,
	output rgbw_pkg::out_word_t                    word_s6
);
	import rgbw_pkg::*;

	logic [2:0][LVL_W-1:0] rgb;
	logic [LVL_W-1:0]      w;
	logic [LVL_W-1:0]      ww;
	out_word_t             word_d;

	// Conversion: white extraction takes the scaled reference off each lane; dropping white clears both white levels.
	always_comb begin
		rgb = side_s5.rgb;
		w   = side_s5.white;
		ww  = side_s5.warm_white;
		case (side_s5.mode)
			MODE_EXTRACT: begin
				for (int i = 0; i < 3; i++) begin
					rgb[i] = side_s5.rgb[i] - scaled_s5[i];
				end
				w = white_s5;
			end
			MODE_DROP_WHITE: begin
				w  = '0;
				ww = '0;
			end
			default: begin
			end
		endcase
	end

	// Channel map of the strip; unused channels stay at zero.
	always_comb begin
		word_d = '0;
		word_d.status = STATUS_OK;
		if (side_s5.mode == MODE_INVALID) begin
			word_d.status = STATUS_BAD_CONV;
		end else begin
			case (side_s5.strip)
				STRIP_SINGLE: begin
					word_d.chan_e = w;
				end
				STRIP_CCT: begin
					word_d.chan_d = w;
					word_d.chan_e = ww;
				end
				STRIP_RGB: begin
					word_d.chan_c = rgb[0];
					word_d.chan_d = rgb[1];
					word_d.chan_e = rgb[2];
				end
				STRIP_RGBW: begin
					word_d.chan_b = rgb[0];
					word_d.chan_c = rgb[1];
					word_d.chan_d = rgb[2];
					word_d.chan_e = w;
				end
				STRIP_RGBWWW: begin
					word_d.chan_a = rgb[0];
					word_d.chan_b = rgb[1];
					word_d.chan_c = rgb[2];
					word_d.chan_d = w;
					word_d.chan_e = ww;
				end
				default: begin
					word_d.status = STATUS_NO_MAP;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv[5]) begin
			word_s6 <= word_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rgb_to_rgbw_channel_mapper.sv =====
// Top level of the RGB to RGBW channel mapper.
//
// Usage:
// - The pixel channel (pixel_valid, pixel_stall, pixel) takes one colour word:
//   message type and red, green, blue, white and warm white levels.
// - The drive channel (drive_valid, drive_stall, drive) returns one word per
//   input word: five channel levels and a status code, in input order.
// - The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   writes the strip type and the white reference; cfg_ready is always high.
//   Write it only while no word is in flight.
// - drive_valid rises once the accepted word has moved through the six-stage
//   pipeline (three divider stages, two scaling stages and the mapping stage);
//   throughput is one word per cycle while the receiver does not stall.
// - When the receiver stalls, the output word holds and the pipeline fills
//   its empty stages; pixel_stall rises only once all six stages hold a word.
// - Reset clears all valid bits and loads the strip type (RGB) and the
//   default white reference; no word is lost or repeated across a stall.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_rgbw_channel_mapper_defines.svh"

module rgb_to_rgbw_channel_mapper (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                pixel_valid,
	output logic                                     pixel_stall,
	input  wire rgbw_pkg::in_word_t                  pixel,
	output logic                                     drive_valid,
	input  wire logic                                drive_stall,
	output rgbw_pkg::out_word_t                      drive,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [rgbw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rgbw_pkg::LVL_W-1:0]          cfg_data
);
	import rgbw_pkg::*;

	logic [STRIP_W-1:0] strip_q;
	logic [LVL_W-1:0]   ref_red_q;
	logic [LVL_W-1:0]   ref_green_q;
	logic [LVL_W-1:0]   ref_blue_q;

	pipe_ctl_t             ctl;
	side_t                 side_in;
	side_t                 side_s3;
	side_t                 side_s5;
	logic [PCT_W-1:0]      pct_s3;
	logic [2:0][LVL_W-1:0] scaled_s5;
	logic [LVL_W-1:0]      white_s5;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_q     <= STRIP_RESET;
			ref_red_q   <= REF_RED_RESET;
			ref_green_q <= REF_GREEN_RESET;
			ref_blue_q  <= REF_BLUE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_STRIP_TYPE:      strip_q     <= cfg_data[STRIP_W-1:0];
				REG_WHITE_REF_RED:   ref_red_q   <= cfg_data;
				REG_WHITE_REF_GREEN: ref_green_q <= cfg_data;
				REG_WHITE_REF_BLUE:  ref_blue_q  <= cfg_data;
			endcase
		end
	end

	// Build the word that enters the pipeline together with the settings it uses.
	always_comb begin
		side_in.mode       = decode_mode(pixel.message_type, strip_q);
		side_in.strip      = strip_q;
		side_in.rgb[0]     = pixel.red;
		side_in.rgb[1]     = pixel.green;
		side_in.rgb[2]     = pixel.blue;
		side_in.white      = pixel.white;
		side_in.warm_white = pixel.warm_white;
		side_in.wref[0]    = ref_red_q;
		side_in.wref[1]    = ref_green_q;
		side_in.wref[2]    = ref_blue_q;
	end

	rgbw_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel_valid),
		.out_stall (drive_stall),
		.ctl       (ctl),
		.in_stall  (pixel_stall)
	);

	rgbw_div u_div (
		.clk     (clk),
		.ctl     (ctl),
		.side_in (side_in),
		.side_s3 (side_s3),
		.pct_s3  (pct_s3)
	);

	rgbw_scale u_scale (
		.clk       (clk),
		.ctl       (ctl),
		.side_s3   (side_s3),
		.pct_s3    (pct_s3),
		.side_s5   (side_s5),
		.scaled_s5 (scaled_s5),
		.white_s5  (white_s5)
	);

	rgbw_map u_map (
		.clk       (clk),
		.ctl       (ctl),
		.side_s5   (side_s5),
		.scaled_s5 (scaled_s5),
		.white_s5  (white_s5),
		.word_s6   (drive)
	);

	assign drive_valid = ctl.vld[NUM_STAGES-1];

	// The input is held off only when every stage holds a word.
	`RGBW_ASSERT_IMPLY(a_stall_full, clk, arst_n, pixel_stall, &ctl.vld, "stall with a free stage")
	// An accepted word lands in the first stage.
	`RGBW_ASSERT_NEXT(a_accept_s1, clk, arst_n, pixel_valid && !pixel_stall, ctl.vld[0], "accepted word lost")
	// A failed conversion drives every channel to zero.
	`RGBW_ASSERT_IMPLY(a_err_zero, clk, arst_n, drive_valid && drive.status != STATUS_OK, (drive.chan_a | drive.chan_b | drive.chan_c | drive.chan_d | drive.chan_e) == '0, "error word with drive")

endmodule

`default_nettype wire
